// ----- design/email_address_syntax_check_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the address syntax checker
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef EMAIL_ADDRESS_SYNTAX_CHECK_MACROS_SVH
`define EMAIL_ADDRESS_SYNTAX_CHECK_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- design/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// Address syntax checker package
// Shared widths, phase codes, register indexes and character class type.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 7;
    localparam int PHASE_W = 2;

    // Parse phase codes
    localparam logic [PHASE_W-1:0] PHASE_LOCAL  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_DOMAIN = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_BAD    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_LOCAL_MAX  = 1'b0;
    localparam logic CFG_DOMAIN_MAX = 1'b1;

    // Reset values of the length limits
    localparam logic [LEN_W-1:0] LOCAL_MAX_RST  = 7'd64;
    localparam logic [LEN_W-1:0] DOMAIN_MAX_RST = 7'd63;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_AT  = 8'h40;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;

    // Classification of one byte
    typedef struct packed {
        logic is_at;      // '@'
        logic is_dot;     // '.'
        logic domain_ok;  // letter, digit, '-' or '.'
        logic local_ok;   // domain set plus local specials
    } char_class_t;

endpackage

`default_nettype wire

// ----- design/email_address_syntax_check.sv -----
// ----------------------------------------------------------------------------
// Email address syntax checker
// Streams an address one byte per request and answers once per address.
// ----------------------------------------------------------------------------
// Takes one address byte per clock on the slave stream; tlast marks the final
// byte. Only the final byte produces an output request, whose bit 0 is 1 when
// the address has exactly one '@', a non-empty local part and domain, only
// allowed characters, no leading, trailing or doubled dot in either part, and
// part lengths within the local and domain length limits. Throughput is one
// byte per clock while input is not stalled. The last byte of an address waits
// in the input register, and the parse logic loads its verdict into the output
// register when that byte advances. The output register stalls input only
// while a finished verdict is held and a further last byte waits behind it.
// Write the limits only between addresses.
`default_nettype none

module email_address_syntax_check (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // Configuration
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [esc_pkg::LEN_W-1:0] cfg_wdata,
    // Slave stream
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,   // [7:0] char_code
    input  wire logic                      s_axis_tlast,   // end_of_address
    // Master stream
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [7:0]                     m_axis_tdata    // [0] address_ok, [7:1] zero
);

    logic [esc_pkg::LEN_W-1:0]  local_max_reg, domain_max_reg;
    logic                       in_valid_reg, in_valid_next;
    logic [esc_pkg::CHAR_W-1:0] in_char_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_ok_reg;
    logic                       advance;
    logic                       load;
    logic                       verdict;
    esc_pkg::char_class_t       char_class;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_max_reg  <= esc_pkg::LOCAL_MAX_RST;
            domain_max_reg <= esc_pkg::DOMAIN_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                esc_pkg::CFG_LOCAL_MAX:  local_max_reg  <= cfg_wdata;
                esc_pkg::CFG_DOMAIN_MAX: domain_max_reg <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // Handshake: a byte moves on unless it needs the busy output register
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    esc_char_class u_char_class (
        .char_code  (in_char_reg),
        .char_class (char_class)
    );

    esc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (advance),
        .last       (in_last_reg),
        .char_class (char_class),
        .local_max  (local_max_reg),
        .domain_max (domain_max_reg),
        .address_ok (verdict)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
            out_ok_reg <= verdict;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_ok_reg};

endmodule

`default_nettype wire

// ----- design/esc_char_class.sv -----
// ----------------------------------------------------------------------------
// Character classifier
// Sorts one byte into the sets allowed in the local part and the domain.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_char_class (
    input  wire logic [esc_pkg::CHAR_W-1:0] char_code,
    output esc_pkg::char_class_t            char_class
);

    logic is_alnum;
    logic is_special;

    // Letters, digits, '-' and '.'
    always_comb
    begin
        is_alnum = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                   ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                   ((char_code >= 8'h30) && (char_code <= 8'h39)) ||
                   (char_code == 8'h2D) || (char_code == esc_pkg::CHAR_DOT);
    end

    // Specials allowed only before the at sign
    always_comb
    begin
        case (char_code)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
            8'h2A, 8'h2B, 8'h2F, 8'h3D, 8'h3F, 8'h5E,
            8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E: is_special = 1'b1;
            default:                                  is_special = 1'b0;
        endcase
    end

    always_comb
    begin
        char_class.is_at     = (char_code == esc_pkg::CHAR_AT);
        char_class.is_dot    = (char_code == esc_pkg::CHAR_DOT);
        char_class.domain_ok = is_alnum;
        char_class.local_ok  = is_alnum || is_special;
    end

endmodule

`default_nettype wire

// ----- design/esc_parser.sv -----
// ----------------------------------------------------------------------------
// Address parser
// Running phase, part length and dot state; verdict on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "email_address_syntax_check_macros.svh"

module esc_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      take,
    input  wire logic                      last,
    input  wire esc_pkg::char_class_t      char_class,
    input  wire logic [esc_pkg::LEN_W-1:0] local_max,
    input  wire logic [esc_pkg::LEN_W-1:0] domain_max,
    output logic                           address_ok
);

    logic [esc_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [esc_pkg::LEN_W-1:0]   length_reg, length_next;
    logic                        dot_reg, dot_next;

    logic [esc_pkg::PHASE_W-1:0] step_phase;
    logic [esc_pkg::LEN_W-1:0]   step_length;
    logic                        step_dot;
    logic                        in_local;
    logic                        active;
    logic                        allowed;
    logic [esc_pkg::LEN_W-1:0]   limit;
    logic [esc_pkg::LEN_W:0]     length_inc;

    assign in_local   = (phase_reg == esc_pkg::PHASE_LOCAL);
    assign active     = in_local || (phase_reg == esc_pkg::PHASE_DOMAIN);
    assign allowed    = in_local ? char_class.local_ok : char_class.domain_ok;
    assign limit      = in_local ? local_max : domain_max;
    assign length_inc = {1'b0, length_reg} + {{esc_pkg::LEN_W{1'b0}}, 1'b1};

    // State after one byte
    always_comb
    begin
        step_phase  = phase_reg;
        step_length = length_reg;
        step_dot    = dot_reg;
        if (active)
        begin
            if (char_class.is_at)
            begin
                if (in_local && (length_reg != '0) && !dot_reg)
                begin
                    step_phase  = esc_pkg::PHASE_DOMAIN;
                    step_length = '0;
                    step_dot    = 1'b0;
                end
                else
                begin
                    step_phase = esc_pkg::PHASE_BAD;
                end
            end
            else if (!allowed)
            begin
                step_phase = esc_pkg::PHASE_BAD;
            end
            else if (char_class.is_dot && ((length_reg == '0) || dot_reg))
            begin
                step_phase = esc_pkg::PHASE_BAD;
            end
            else
            begin
                step_dot = char_class.is_dot;
                if (length_inc > {1'b0, limit})
                    step_phase = esc_pkg::PHASE_BAD;
                else
                    step_length = length_inc[esc_pkg::LEN_W-1:0];
            end
        end
    end

    // Verdict on the state that the last byte leaves
    assign address_ok = (step_phase == esc_pkg::PHASE_DOMAIN) &&
                        (step_length != '0) && !step_dot;

    // Clear for the next address after the last byte
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        dot_next    = dot_reg;
        if (take)
        begin
            if (last)
            begin
                phase_next  = esc_pkg::PHASE_LOCAL;
                length_next = '0;
                dot_next    = 1'b0;
            end
            else
            begin
                phase_next  = step_phase;
                length_next = step_length;
                dot_next    = step_dot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= esc_pkg::PHASE_LOCAL;
            length_reg <= '0;
            dot_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            dot_reg    <= dot_next;
        end
    end

    // Checks
    `ESC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, take && last,
        (phase_reg == esc_pkg::PHASE_LOCAL) && (length_reg == '0) && !dot_reg,
        "parser state not cleared after last byte")
    `ESC_ASSERT_NEXT(a_bad_sticks, clk, rst_n,
        !active && !(take && last), !active,
        "rejected address left the rejected phase")
    `ESC_ASSERT_NOW(a_dot_has_length, clk, rst_n, dot_reg, length_reg != '0,
        "dot recorded in an empty part")

endmodule

`default_nettype wire

// ----- sim/tb_email_address_syntax_check.sv -----
// ----------------------------------------------------------------------------
// Testbench for the address syntax checker
// Streams directed and random addresses through the checker under random
// sender bursts and receiver stalls. A local predictor runs on every accepted
// byte, and each verdict request is compared in order with the predicted one.
// The length limits are changed between phases while the checker is idle.
// ----------------------------------------------------------------------------
module tb_email_address_syntax_check;

    // One byte of an address as offered on the input stream
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } addr_byte_t;

    // Receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_ALTERNATE
    } rx_mode_t;

    // Ways a generated address gets corrupted
    typedef enum int {
        FAULT_SWAP_BYTE,
        FAULT_ADD_DOT,
        FAULT_ADD_AT,
        FAULT_DROP_BYTE,
        FAULT_LEAD_DOT,
        FAULT_TRAIL_DOT,
        FAULT_TWO_DOTS
    } fault_t;

    localparam int HOLD_OFF_CYCLES = 300;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = esc_pkg::CFG_LOCAL_MAX;
    logic [esc_pkg::LEN_W-1:0] cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;     // [7:0] char_code
    logic                      s_axis_tlast = 1'b0;   // end_of_address
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;          // [0] address_ok, [7:1] zero

    // Bytes waiting to be sent, verdicts waiting to arrive
    addr_byte_t address_bytes[$];
    logic       pending_verdicts[$];
    logic [7:0] addr_text[$];
    int         bytes_queued = 0;
    int         mismatches = 0;
    logic       pressure = 1'b0;

    // Predicted checker state and limits
    logic [esc_pkg::PHASE_W-1:0] chk_phase = esc_pkg::PHASE_LOCAL;
    logic [esc_pkg::LEN_W-1:0]   chk_len = '0;
    logic                        chk_dot = 1'b0;
    logic [esc_pkg::LEN_W-1:0]   local_limit = esc_pkg::LOCAL_MAX_RST;
    logic [esc_pkg::LEN_W-1:0]   domain_limit = esc_pkg::DOMAIN_MAX_RST;

    // Sender and receiver pacing
    int       burst_left = 1;
    int       gap_left = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    logic     pressure_seen = 1'b0;
    rx_mode_t rx_mode = RX_ALWAYS;

    string host_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-";
    string special_chars = "!#$%&'*+/=?^_{|}~";

    email_address_syntax_check u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic is_host_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "-" || c == esc_pkg::CHAR_DOT;
    endfunction

    function automatic logic is_local_special(input logic [7:0] c);
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "/", "=", "?", "^", "_",
            8'h60, "{", "|", "}", "~":  // 8'h60 is the backtick
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Advance the predicted state by one accepted byte
    function void judge_byte(input logic [7:0] c);
        logic                      allowed;
        logic [esc_pkg::LEN_W-1:0] limit;
        if (chk_phase != esc_pkg::PHASE_LOCAL && chk_phase != esc_pkg::PHASE_DOMAIN)
            return;
        if (c == esc_pkg::CHAR_AT)
        begin
            if (chk_phase == esc_pkg::PHASE_LOCAL && chk_len != 0 && !chk_dot)
            begin
                chk_phase = esc_pkg::PHASE_DOMAIN;
                chk_len = '0;
                chk_dot = 1'b0;
            end
            else
                chk_phase = esc_pkg::PHASE_BAD;
            return;
        end
        allowed = is_host_char(c) ||
                  (chk_phase == esc_pkg::PHASE_LOCAL && is_local_special(c));
        if (!allowed)
        begin
            chk_phase = esc_pkg::PHASE_BAD;
            return;
        end
        if (c == esc_pkg::CHAR_DOT)
        begin
            if (chk_len == 0 || chk_dot)
            begin
                chk_phase = esc_pkg::PHASE_BAD;
                return;
            end
            chk_dot = 1'b1;
        end
        else
            chk_dot = 1'b0;
        limit = (chk_phase == esc_pkg::PHASE_LOCAL) ? local_limit : domain_limit;
        if ({1'b0, chk_len} + 8'd1 > {1'b0, limit})
        begin
            chk_phase = esc_pkg::PHASE_BAD;
            return;
        end
        chk_len = chk_len + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: bursts of requests with random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_input
        addr_byte_t item;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !s_axis_tready)
        begin
            // request still waiting, hold it
        end
        else if (gap_left > 0 && !pressure)
        begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end
        else if (address_bytes.size() > 0)
        begin
            item = address_bytes.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item.code;
            s_axis_tlast  <= item.last;
            if (burst_left <= 1)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                burst_left--;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver ready: changing stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_ready
        logic take;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (pressure && !pressure_seen)
                hold_left = HOLD_OFF_CYCLES;
            pressure_seen = pressure;
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                else
                    mode_left--;
                case (rx_mode)
                    RX_ALWAYS: take = 1'b1;
                    RX_MOSTLY: take = ($urandom_range(0, 3) != 0);
                    RX_RARELY: take = ($urandom_range(0, 3) == 0);
                    default:   take = ~m_axis_tready;
                endcase
            end
            m_axis_tready <= take;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track limits, predict verdicts, check output requests
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        logic expected;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == esc_pkg::CFG_LOCAL_MAX)
                    local_limit = cfg_wdata;
                else
                    domain_limit = cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict: expected none, got %0h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    expected = pending_verdicts.pop_front();
                    if (m_axis_tdata !== {7'b0, expected})
                    begin
                        $display("%0t: verdict mismatch: expected %0h, got %0h",
                                 $time, {7'b0, expected}, m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                judge_byte(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    pending_verdicts.push_back(chk_phase == esc_pkg::PHASE_DOMAIN &&
                                               chk_len != 0 && !chk_dot);
                    chk_phase = esc_pkg::PHASE_LOCAL;
                    chk_len = '0;
                    chk_dot = 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_limit(input logic idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[esc_pkg::LEN_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Move the text being built into the send queue, tlast on its final byte
    task automatic queue_address();
        addr_byte_t item;
        if (addr_text.size() == 0)
            return;
        for (int i = 0; i < addr_text.size(); i++)
        begin
            item.code = addr_text[i];
            item.last = (i == addr_text.size() - 1);
            address_bytes.push_back(item);
        end
        bytes_queued += addr_text.size();
        addr_text.delete();
    endtask

    task automatic push_text(input string s);
        addr_text.delete();
        for (int i = 0; i < s.len(); i++)
            addr_text.push_back(s[i]);
        queue_address();
    endtask

    task automatic push_single(input logic [7:0] c);
        addr_text.delete();
        addr_text.push_back(c);
        queue_address();
    endtask

    function automatic logic [7:0] local_char();
        int idx;
        if ($urandom_range(0, 3) != 0)
            return host_chars[$urandom_range(0, host_chars.len() - 1)];
        idx = $urandom_range(0, special_chars.len());
        return (idx == special_chars.len()) ? 8'h60 : special_chars[idx];
    endfunction

    // Append one part of n bytes, dots only between other characters
    task automatic add_part(input int n, input logic local_side);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && i < n - 1 &&
                addr_text[addr_text.size() - 1] != esc_pkg::CHAR_DOT &&
                $urandom_range(0, 4) == 0)
                addr_text.push_back(esc_pkg::CHAR_DOT);
            else if (local_side)
                addr_text.push_back(local_char());
            else
                addr_text.push_back(host_chars[$urandom_range(0, host_chars.len() - 1)]);
        end
    endtask

    task automatic make_address(input int lp, input int dp, input logic faulty);
        int     pos;
        fault_t kind;
        addr_text.delete();
        add_part(lp, 1'b1);
        addr_text.push_back(esc_pkg::CHAR_AT);
        add_part(dp, 1'b0);
        if (faulty)
        begin
            pos = $urandom_range(0, addr_text.size() - 1);
            kind = fault_t'($urandom_range(0, 6));
            case (kind)
                FAULT_SWAP_BYTE: addr_text[pos] = 8'($urandom_range(0, 255));
                FAULT_ADD_DOT:   addr_text.insert(pos, esc_pkg::CHAR_DOT);
                FAULT_ADD_AT:    addr_text.insert(pos, esc_pkg::CHAR_AT);
                FAULT_DROP_BYTE: addr_text.delete(pos);
                FAULT_LEAD_DOT:  addr_text.push_front(esc_pkg::CHAR_DOT);
                FAULT_TRAIL_DOT: addr_text.push_back(esc_pkg::CHAR_DOT);
                default:
                begin
                    addr_text.insert(pos, esc_pkg::CHAR_DOT);
                    addr_text.insert(pos, esc_pkg::CHAR_DOT);
                end
            endcase
        end
        queue_address();
    endtask

    // Part length: mostly short, sometimes empty, at the limit or just over
    function automatic int pick_len(input int limit);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 0;
        if (r == 1)
            return limit;
        if (r == 2)
            return limit + 1;
        return $urandom_range(1, (limit < 8) ? limit : 8);
    endfunction

    // Wait until all bytes are sent and all verdicts are in, then let the
    // pipeline settle so a trailing non-last byte is fully absorbed
    task automatic wait_drain();
        while (address_bytes.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input int lmax, input int dmax, input int budget);
        int start;
        write_limit(esc_pkg::CFG_LOCAL_MAX, lmax);
        write_limit(esc_pkg::CFG_DOMAIN_MAX, dmax);
        @(negedge clk);
        start = bytes_queued;
        // parts exactly at the limits, then one byte over
        make_address(lmax, 2, 1'b0);
        make_address(2, dmax, 1'b0);
        make_address(lmax + 1, 1, 1'b0);
        make_address(1, dmax + 1, 1'b0);
        while (bytes_queued - start < budget + 8)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // raw byte noise
                addr_text.delete();
                repeat ($urandom_range(1, 6))
                    addr_text.push_back(8'($urandom_range(0, 255)));
                queue_address();
            end
            else
                make_address(pick_len(lmax), pick_len(dmax), $urandom_range(0, 2) == 0);
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases under the reset limits
        push_text("a@b");
        push_single(esc_pkg::CHAR_AT);
        push_single("x");
        push_text(".@b");
        push_text("a.@b");
        push_text("a@b@");
        push_text("a@b.");
        push_text("~@Z");
        push_text("a@b..c");
        push_single(8'hFF);
        push_single(8'h00);
        wait_drain();

        // Random phases over several limit settings
        run_phase(1, 1, 100);
        run_phase(126, 126, 30);
        pressure = 1'b1;
        run_phase(4, 3, 150);
        pressure = 1'b0;
        repeat (3)
            run_phase($urandom_range(1, 20), $urandom_range(1, 20), 90);

        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("[email_address_syntax_check] OK");
        else
            $display("[email_address_syntax_check] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("[email_address_syntax_check] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/esc_pkg.sv
design/esc_char_class.sv
design/esc_parser.sv
design/email_address_syntax_check.sv
sim/tb_email_address_syntax_check.sv
